// ===== hdl/tspg_pkg.sv =====
// Package for the three-phase sine PWM generator: widths, constants and the
// quarter-wave sine table. No dependencies; used by every file under hdl.
package tspg_pkg;

    localparam int FREQ_W   = 8;
    localparam int DUTY_W   = 15;
    localparam int ANGLE_W  = 16;
    localparam int SINE_W   = 14;
    localparam int DIFF_W   = 11;
    localparam int FRAC_W   = 10;
    localparam int IDX_W    = 4;
    localparam int SCALE_W  = 17;
    localparam int STEP_W   = 16;
    localparam int MUL_W    = 17;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int LUT_SIZE = 1 << FREQ_W;

    localparam int TICK_RATE_DEFAULT      = 8000;
    localparam int KNEE_FREQUENCY_DEFAULT = 25;

    localparam logic [DUTY_W-1:0]  DUTY_CENTER    = 15'd10500;
    localparam logic [ANGLE_W-1:0] PHASE_OFFSET_B = 16'h5555;
    localparam logic [ANGLE_W-1:0] PHASE_OFFSET_C = 16'hAAAA;
    localparam int                 FULL_SCALE     = 32'h10000;

    // Table lookup result for one phase angle
    typedef struct packed {
        logic [SINE_W-1:0] t_lo;
        logic [DIFF_W-1:0] diff;
        logic [FRAC_W-1:0] frac;
        logic              neg;
    } fold_t;

    // Quarter-wave sine, 17 points from 0 to a quarter turn
    function automatic logic [SINE_W-1:0] quarter_sine(input logic [IDX_W:0] idx);
        logic [SINE_W-1:0] v;
        case (idx)
            5'd0:    v = 14'd0;
            5'd1:    v = 14'd1029;
            5'd2:    v = 14'd2048;
            5'd3:    v = 14'd3048;
            5'd4:    v = 14'd4018;
            5'd5:    v = 14'd4950;
            5'd6:    v = 14'd5833;
            5'd7:    v = 14'd6661;
            5'd8:    v = 14'd7425;
            5'd9:    v = 14'd8117;
            5'd10:   v = 14'd8730;
            5'd11:   v = 14'd9260;
            5'd12:   v = 14'd9701;
            5'd13:   v = 14'd10048;
            5'd14:   v = 14'd10298;
            5'd15:   v = 14'd10449;
            5'd16:   v = 14'd10500;
            default: v = 14'd10500;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/tspg_mult.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on tspg_pkg for operand widths.
module tspg_mult (
    input  logic                        aclk,
    input  logic [tspg_pkg::MUL_W-1:0]  op_a,
    input  logic [tspg_pkg::MUL_W-1:0]  op_b,
    output logic [tspg_pkg::PROD_W-1:0] prod
);

    logic [tspg_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= tspg_pkg::PROD_W'(op_a) * tspg_pkg::PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/tspg_phase_fold.sv =====
// Quadrant fold and sine table lookup for one 16-bit phase angle.
// Depends on tspg_pkg for the table and the fold_t result type.
module tspg_phase_fold (
    input  logic [tspg_pkg::ANGLE_W-1:0] angle,
    output tspg_pkg::fold_t              fold
);

    logic [tspg_pkg::ANGLE_W-1:0] folded;
    logic [tspg_pkg::IDX_W-1:0]   idx;
    logic [tspg_pkg::SINE_W-1:0]  t_hi;

    // Mirror the second and fourth quadrants
    assign folded = angle[14] ? ~angle : angle;
    assign idx    = folded[13:10];
    assign t_hi   = tspg_pkg::quarter_sine({1'b0, idx} + 5'd1);

    always_comb begin
        fold.t_lo = tspg_pkg::quarter_sine({1'b0, idx});
        fold.diff = tspg_pkg::DIFF_W'(t_hi - fold.t_lo);
        fold.frac = folded[9:0];
        fold.neg  = angle[15];
    end

endmodule

// ===== hdl/three_phase_sine_pwm_generator.sv =====
// Top level of the three-phase sine PWM generator with volts-per-hertz scaling.
// Depends on tspg_pkg, tspg_mult and tspg_phase_fold.
//
// Use: present one signed frequency per PWM tick on s_frequency with s_valid.
// The transfer happens when s_valid and s_ready are high together. The block
// then works out the three compare values m_duty_a/b/c (phase angle, angle
// plus a third turn, angle plus two thirds) and offers them with m_valid.
// The result transfer happens when m_valid and m_ready are both high.
//
// Sequence: one shared multiplier does two products per phase (interpolation,
// then amplitude scaling), three phases in turn, and the sequencer then loads
// the output register. s_ready is high only while the sequencer is idle, so
// a new item is taken only once the last one has gone to the output register.
// The output register holds a finished result while the next item is already
// being worked on; if the receiver still stalls when that item is done, the
// sequencer waits and keeps s_ready low.
//
// Reset (aresetn low, synchronous) zeroes the phase accumulator, empties the
// output register and returns the sequencer to idle.
module three_phase_sine_pwm_generator #(
    parameter int TICK_RATE      = tspg_pkg::TICK_RATE_DEFAULT,
    parameter int KNEE_FREQUENCY = tspg_pkg::KNEE_FREQUENCY_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [tspg_pkg::FREQ_W-1:0] s_frequency,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tspg_pkg::DUTY_W-1:0]       m_duty_a,
    output logic [tspg_pkg::DUTY_W-1:0]       m_duty_b,
    output logic [tspg_pkg::DUTY_W-1:0]       m_duty_c
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INTERP,
        S_SCALE,
        S_STORE,
        S_WRITE
    } state_t;

    localparam int PhaseCount = 3;

    // Amplitude and phase step tables, indexed by the frequency magnitude.
    // Every entry is worked out at elaboration.
    logic [tspg_pkg::SCALE_W-1:0] scale_lut [tspg_pkg::LUT_SIZE];
    logic [tspg_pkg::STEP_W-1:0]  step_lut  [tspg_pkg::LUT_SIZE];

    for (genvar gi = 0; gi < tspg_pkg::LUT_SIZE; gi++) begin : g_lut
        localparam int ScaleVal = (gi <= KNEE_FREQUENCY) ?
                                  (tspg_pkg::FULL_SCALE * gi) / KNEE_FREQUENCY :
                                  tspg_pkg::FULL_SCALE;
        localparam int StepVal  = (65535 * gi) / TICK_RATE;
        assign scale_lut[gi] = tspg_pkg::SCALE_W'(ScaleVal);
        assign step_lut[gi]  = tspg_pkg::STEP_W'(StepVal);
    end

    state_t                        state_reg;
    logic [1:0]                    phase_reg;
    logic [tspg_pkg::ANGLE_W-1:0]  phase_angle_reg;
    logic [tspg_pkg::ANGLE_W-1:0]  base_angle_reg;
    logic [tspg_pkg::SCALE_W-1:0]  scale_reg;
    logic [tspg_pkg::SINE_W-1:0]   t_lo_reg;
    logic                          neg_reg;
    logic [tspg_pkg::DUTY_W-1:0]   duty_a_reg;
    logic [tspg_pkg::DUTY_W-1:0]   duty_b_reg;
    logic [tspg_pkg::DUTY_W-1:0]   duty_c_reg;
    logic                          m_valid_reg;
    logic [tspg_pkg::DUTY_W-1:0]   m_duty_a_reg;
    logic [tspg_pkg::DUTY_W-1:0]   m_duty_b_reg;
    logic [tspg_pkg::DUTY_W-1:0]   m_duty_c_reg;

    logic [tspg_pkg::FREQ_W-1:0]   freq_mag;
    logic [tspg_pkg::STEP_W-1:0]   step_mag;
    logic [tspg_pkg::ANGLE_W-1:0]  phase_offset;
    logic [tspg_pkg::ANGLE_W-1:0]  cur_angle;
    tspg_pkg::fold_t               fold;
    logic [tspg_pkg::MUL_W-1:0]    mul_a;
    logic [tspg_pkg::MUL_W-1:0]    mul_b;
    logic [tspg_pkg::PROD_W-1:0]   prod;
    logic [tspg_pkg::SINE_W-1:0]   sine_val;
    logic [tspg_pkg::SINE_W-1:0]   mag_val;
    logic [tspg_pkg::DUTY_W-1:0]   duty_val;
    logic                          s_xfer;
    logic                          out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Magnitude of the signed frequency; -128 maps to 128
    assign freq_mag = s_frequency[tspg_pkg::FREQ_W-1] ?
                      tspg_pkg::FREQ_W'(-s_frequency) : tspg_pkg::FREQ_W'(s_frequency);
    assign step_mag = step_lut[freq_mag];

    always_comb begin
        case (phase_reg)
            2'd0:    phase_offset = '0;
            2'd1:    phase_offset = tspg_pkg::PHASE_OFFSET_B;
            default: phase_offset = tspg_pkg::PHASE_OFFSET_C;
        endcase
    end

    assign cur_angle = base_angle_reg + phase_offset;

    tspg_phase_fold u_fold (
        .angle (cur_angle),
        .fold  (fold)
    );

    // Feed the shared multiplier: interpolation first, then amplitude
    always_comb begin
        case (state_reg)
            S_INTERP: begin
                mul_a = tspg_pkg::MUL_W'(fold.frac);
                mul_b = tspg_pkg::MUL_W'(fold.diff);
            end
            S_SCALE: begin
                mul_a = tspg_pkg::MUL_W'(sine_val);
                mul_b = scale_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    tspg_mult u_mult (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Interpolated sine: table point plus fraction of the step, floored
    assign sine_val = t_lo_reg + tspg_pkg::SINE_W'(prod[20:10]);
    // Scaled magnitude: drop the 16 fractional bits of the scale
    assign mag_val  = prod[29:16];
    assign duty_val = neg_reg ?
                      tspg_pkg::DUTY_CENTER - tspg_pkg::DUTY_W'(mag_val) :
                      tspg_pkg::DUTY_CENTER + tspg_pkg::DUTY_W'(mag_val);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            phase_reg       <= '0;
            phase_angle_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // Drop the output once the receiver has taken it, unless a new
            // result loads at the same edge
            if (m_valid_reg && m_ready && state_reg != S_WRITE) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_xfer) begin
                        // Capture the angle for this tick, then advance it
                        base_angle_reg <= phase_angle_reg;
                        scale_reg      <= scale_lut[freq_mag];
                        phase_angle_reg <= s_frequency[tspg_pkg::FREQ_W-1] ?
                                           phase_angle_reg - step_mag :
                                           phase_angle_reg + step_mag;
                        phase_reg      <= '0;
                        state_reg      <= S_INTERP;
                    end
                end
                S_INTERP: begin
                    t_lo_reg  <= fold.t_lo;
                    neg_reg   <= fold.neg;
                    state_reg <= S_SCALE;
                end
                S_SCALE: begin
                    state_reg <= S_STORE;
                end
                S_STORE: begin
                    case (phase_reg)
                        2'd0:    duty_a_reg <= duty_val;
                        2'd1:    duty_b_reg <= duty_val;
                        default: duty_c_reg <= duty_val;
                    endcase
                    if (phase_reg == 2'(PhaseCount - 1)) begin
                        state_reg <= S_WRITE;
                    end else begin
                        phase_reg <= phase_reg + 2'd1;
                        state_reg <= S_INTERP;
                    end
                end
                S_WRITE: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        m_duty_a_reg <= duty_a_reg;
                        m_duty_b_reg <= duty_b_reg;
                        m_duty_c_reg <= duty_c_reg;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_duty_a = m_duty_a_reg;
    assign m_duty_b = m_duty_b_reg;
    assign m_duty_c = m_duty_c_reg;

endmodule

// ===== dv/tspg_duty_monitor.sv =====
// Watches both channels of the three-phase sine PWM generator, predicts the duty
// triple for each input transfer and compares it with the result transfers.
// Depends on tspg_pkg for widths and the duty centre and phase offsets.
module tspg_duty_monitor #(
    parameter int TICK_RATE      = tspg_pkg::TICK_RATE_DEFAULT,
    parameter int KNEE_FREQUENCY = tspg_pkg::KNEE_FREQUENCY_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic signed [tspg_pkg::FREQ_W-1:0] s_frequency,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [tspg_pkg::DUTY_W-1:0]        m_duty_a,
    input  logic [tspg_pkg::DUTY_W-1:0]        m_duty_b,
    input  logic [tspg_pkg::DUTY_W-1:0]        m_duty_c,
    output int                                 fail_count,
    output int                                 duties_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [tspg_pkg::FREQ_W-1:0] freq;
        logic [tspg_pkg::DUTY_W-1:0]        duty_a;
        logic [tspg_pkg::DUTY_W-1:0]        duty_b;
        logic [tspg_pkg::DUTY_W-1:0]        duty_c;
    } duty_triple_t;

    // quarter-wave sine points, zero to a quarter turn
    int unsigned sine_points [17] = '{
        0, 1029, 2048, 3048, 4018, 4950, 5833, 6661, 7425,
        8117, 8730, 9260, 9701, 10048, 10298, 10449, 10500
    };

    duty_triple_t                 pending_duties [$];
    logic [tspg_pkg::ANGLE_W-1:0] model_angle;

    initial begin
        fail_count  = 0;
        duties_owed = 0;
        model_angle = '0;
    end

    function automatic int unsigned amplitude_for(input int freq);
        int unsigned mag;
        mag = (freq < 0) ? -freq : freq;
        if (mag <= KNEE_FREQUENCY)
            return (32'h10000 * mag) / KNEE_FREQUENCY;
        return 32'h10000;
    endfunction

    // fold by quadrant, interpolate between table points, scale and centre
    function automatic logic [tspg_pkg::DUTY_W-1:0] phase_compare(
        input logic [tspg_pkg::ANGLE_W-1:0] ang,
        input int unsigned                  amp
    );
        logic [tspg_pkg::ANGLE_W-1:0] folded;
        int unsigned                  idx;
        int unsigned                  interp;
        int unsigned                  swing;
        folded = ang[14] ? ~ang : ang;
        idx    = folded[13:10];
        interp = sine_points[idx]
               + (folded[9:0] * (sine_points[idx + 1] - sine_points[idx])) / 1024;
        swing  = (interp * amp) >> 16;
        if (ang[15])
            return tspg_pkg::DUTY_W'(int'(tspg_pkg::DUTY_CENTER) - int'(swing));
        return tspg_pkg::DUTY_W'(int'(tspg_pkg::DUTY_CENTER) + int'(swing));
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] duty check: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input int freq,
                                 input logic [tspg_pkg::DUTY_W-1:0] got,
                                 input logic [tspg_pkg::DUTY_W-1:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s for f=%0d is %0d, want %0d", name, freq, got, want));
    endtask

    always @(posedge aclk) begin
        duty_triple_t want;
        int           freq;
        int unsigned  amp;
        int           step;
        if (!aresetn) begin
            model_angle = '0;
            pending_duties.delete();
            duties_owed <= 0;
        end else begin
            // retire first, so a result never meets the item taken at the same edge
            if (m_valid && m_ready) begin
                if (pending_duties.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result %0d/%0d/%0d",
                                            m_duty_a, m_duty_b, m_duty_c));
                end else begin
                    want = pending_duties.pop_front();
                    compare_field("duty_a", want.freq, m_duty_a, want.duty_a);
                    compare_field("duty_b", want.freq, m_duty_b, want.duty_b);
                    compare_field("duty_c", want.freq, m_duty_c, want.duty_c);
                end
            end
            if (s_valid && s_ready) begin
                freq        = s_frequency;
                amp         = amplitude_for(freq);
                want.freq   = s_frequency;
                want.duty_a = phase_compare(model_angle, amp);
                want.duty_b = phase_compare(model_angle + tspg_pkg::PHASE_OFFSET_B, amp);
                want.duty_c = phase_compare(model_angle + tspg_pkg::PHASE_OFFSET_C, amp);
                pending_duties.push_back(want);
                step        = (65535 * freq) / TICK_RATE;
                model_angle = model_angle + tspg_pkg::ANGLE_W'(step);
            end
            duties_owed <= pending_duties.size();
        end
    end

endmodule

// ===== dv/tb_three_phase_sine_pwm_generator.sv =====
// Top of the regression for the three-phase sine PWM generator: clock, reset,
// frequency stimulus and result back-pressure, and the final verdict.
// Depends on tspg_pkg, the block under hdl and tspg_duty_monitor.
module tb_three_phase_sine_pwm_generator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_RATE      = 8000;
    localparam int KNEE_FREQUENCY = 25;
    localparam int RANDOM_TICKS   = 1626;
    localparam int QUIET_TAIL     = 150;
    // long receiver hold-off: starts once this many ticks are in, lasts this long
    localparam int HOLD_AT_TICK   = 500;
    localparam int HOLD_CYCLES    = 400;
    // run limit for the watchdog, well above the slowest legal run
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 24;

    logic                               aclk;
    logic                               aresetn     = 1'b0;
    logic                               s_valid     = 1'b0;
    logic                               s_ready;
    logic signed [tspg_pkg::FREQ_W-1:0] s_frequency = '0;
    logic                               m_valid;
    logic                               m_ready     = 1'b0;
    logic [tspg_pkg::DUTY_W-1:0]        m_duty_a;
    logic [tspg_pkg::DUTY_W-1:0]        m_duty_b;
    logic [tspg_pkg::DUTY_W-1:0]        m_duty_c;

    int fail_count;
    int duties_owed;

    // state of the sender and the receiver process; ticks_sent and stall_pct are shared
    int ticks_sent       = 0;
    int gap_pct          = 0;
    int stall_pct        = 0;
    bit long_hold_done   = 1'b0;

    three_phase_sine_pwm_generator #(
        .TICK_RATE      (TICK_RATE),
        .KNEE_FREQUENCY (KNEE_FREQUENCY)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_frequency (s_frequency),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_duty_a    (m_duty_a),
        .m_duty_b    (m_duty_b),
        .m_duty_c    (m_duty_c)
    );

    tspg_duty_monitor #(
        .TICK_RATE      (TICK_RATE),
        .KNEE_FREQUENCY (KNEE_FREQUENCY)
    ) duty_monitor (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_frequency (s_frequency),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_duty_a    (m_duty_a),
        .m_duty_b    (m_duty_b),
        .m_duty_c    (m_duty_c),
        .fail_count  (fail_count),
        .duties_owed (duties_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Offer one frequency tick and hold it until the transfer. An optional
    // idle burst goes in front; valid is only lowered when a burst follows,
    // so back-to-back ticks keep valid high with a single update per edge.
    task automatic send_tick(input logic signed [tspg_pkg::FREQ_W-1:0] freq);
        int gap;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_frequency <= freq;
        // s_ready read here is the value from before this edge's updates
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
    endtask

    // Receiver: random stall bursts, and once a long hold-off so that the
    // output register and the sequencer both fill and s_ready drops.
    initial begin
        int burst;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (!long_hold_done && ticks_sent >= HOLD_AT_TICK) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                long_hold_done = 1'b1;
                m_ready <= 1'b1;
            end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                burst = $urandom_range(1, 12);
                repeat (burst) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if the slowest correct run is exceeded.
    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("three_phase_sine_pwm_generator regression: fail");
        $finish;
    end

    initial begin
        // Directed ticks: zero, both sides of the knee, the range ends, values
        // beyond the range that are not clamped, and the 8-bit extremes.
        logic signed [tspg_pkg::FREQ_W-1:0] directed_ticks [24];
        logic signed [tspg_pkg::FREQ_W-1:0] freq;
        int                                 pattern;
        int                                 run_left;
        int                                 run_freq;
        int                                 ramp_dir;

        directed_ticks = '{
            8'sd0, 8'sd1, -8'sd1, 8'sd24, 8'sd25, -8'sd25, 8'sd26, -8'sd26,
            8'sd70, -8'sd70, 8'sd71, -8'sd71, 8'sd127, -8'sd128, -8'sd127, 8'sd50,
            -8'sd50, 8'sd13, -8'sd13, 8'sd0, 8'sd2, 8'sd100, -8'sd100, 8'sd35
        };
        run_left = 0;
        run_freq = 0;
        ramp_dir = 1;
        pattern  = 0;

        // hold reset, then release it for good
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gap_pct   = 20;
        stall_pct = 20;
        foreach (directed_ticks[k])
            send_tick(directed_ticks[k]);

        for (int n = 0; n < RANDOM_TICKS; n++) begin
            // re-pick the idling mix every band of ticks, quiet on the tail
            if (n % 150 == 0) begin
                case ($urandom_range(0, 3))
                    0:       gap_pct = 0;
                    1:       gap_pct = 10;
                    2:       gap_pct = 35;
                    default: gap_pct = 70;
                endcase
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    2:       stall_pct = 35;
                    default: stall_pct = 70;
                endcase
            end
            if (n >= RANDOM_TICKS - QUIET_TAIL) begin
                gap_pct   = 0;
                stall_pct = 0;
            end

            // mostly steady or ramping frequency so the angle sweeps round,
            // with per-tick noise and some values outside the nominal range
            if (run_left == 0) begin
                pattern  = $urandom_range(0, 9);
                run_left = $urandom_range(4, 40);
                run_freq = int'($urandom_range(0, 140)) - 70;
                ramp_dir = $urandom_range(0, 1) ? 1 : -1;
            end
            run_left--;
            if (pattern <= 3) begin
                freq = tspg_pkg::FREQ_W'(run_freq);
            end else if (pattern <= 5) begin
                freq = tspg_pkg::FREQ_W'(run_freq);
                if (run_freq + ramp_dir > 70 || run_freq + ramp_dir < -70)
                    ramp_dir = -ramp_dir;
                run_freq += ramp_dir;
            end else if (pattern <= 8) begin
                freq = tspg_pkg::FREQ_W'(int'($urandom_range(0, 140)) - 70);
            end else begin
                freq = tspg_pkg::FREQ_W'($urandom_range(0, 255));
            end
            send_tick(freq);
        end

        s_valid <= 1'b0;

        // drain: every predicted triple back, then DRAIN_CYCLES more for strays
        while (duties_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && duties_owed == 0)
            $display("three_phase_sine_pwm_generator regression: pass");
        else
            $display("three_phase_sine_pwm_generator regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tspg_pkg.sv
hdl/tspg_mult.sv
hdl/tspg_phase_fold.sv
hdl/three_phase_sine_pwm_generator.sv
dv/tspg_duty_monitor.sv
dv/tb_three_phase_sine_pwm_generator.sv
